FILE: rtl/assert_macros.svh
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/ikv_pkg.sv
`default_nettype none
package ikv_pkg;

    localparam int MAX_KEY_BYTES = 16;
    localparam int KEY_POS_W     = 5;
    localparam int KEY_BITS      = 128;

    localparam logic [KEY_POS_W-1:0] MAX_KEY_POS = KEY_POS_W'(MAX_KEY_BYTES);
    localparam logic [KEY_POS_W-1:0] KEY_POS_SAT = '1;
    localparam logic [7:0]           SEP_CHAR    = 8'h5C;
    localparam logic [7:0]           NUL_CHAR    = 8'h00;

    typedef enum logic [1:0] {
        CFG_KEY_LOW   = 2'd0,
        CFG_KEY_HIGH  = 2'd1,
        CFG_KEY_LEN   = 2'd2,
        CFG_VAL_LIMIT = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_EXPECT = 2'd0,
        PH_KEY    = 2'd1,
        PH_VALUE  = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic [KEY_BITS-1:0]  key_bytes;
        logic [KEY_POS_W-1:0] key_length;
        logic [7:0]           value_limit;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] value_char;
        logic       value_char_valid;
        logic       search_done;
        logic       key_found;
        logic [7:0] value_length;
    } t_result;

endpackage
`default_nettype wire

FILE: rtl/infostring_key_value_extract_core.sv
// channel  | direction | handshake                 | payload
// input    | in        | i_in_valid / o_in_ready   | i_in_char, i_is_last
// result   | out       | o_out_valid / i_out_ready | o_value_char .. o_value_length
// config   | in        | i_cfg_we                  | i_cfg_idx, i_cfg_wdata
//
// one character per clock sustained while the output is not stalled
// the input register feeds the parser, whose result lands in the output register
// a transaction that yields no result simply leaves the input register
// while the output is stalled the input register holds and o_in_ready follows it
// synchronous active-low reset: parser expects a leading backslash, value limit 255
`default_nettype none
module infostring_key_value_extract_core
    import ikv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_in_char,
    input  wire logic        i_is_last,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_value_char,
    output logic             o_value_char_valid,
    output logic             o_search_done,
    output logic             o_key_found,
    output logic [7:0]       o_value_length
);

    t_cfg    cfg;
    t_result res;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;
    logic       adv;

    ikv_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    ikv_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_step  (adv),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_res   (res)
    );

    assign adv        = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_char <= i_in_char;
            r_in_last <= i_is_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_value_char       = r_out.value_char;
    assign o_value_char_valid = r_out.value_char_valid;
    assign o_search_done      = r_out.search_done;
    assign o_key_found        = r_out.key_found;
    assign o_value_length     = r_out.value_length;

endmodule
`default_nettype wire

FILE: rtl/ikv_cfg_regs.sv
`default_nettype none
module ikv_cfg_regs
    import ikv_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [63:0] i_cfg_wdata,
    output t_cfg             o_cfg
);

    logic [63:0]          r_key_low;
    logic [63:0]          r_key_high;
    logic [KEY_POS_W-1:0] r_key_len;
    logic [7:0]           r_val_limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low   <= '0;
            r_key_high  <= '0;
            r_key_len   <= '0;
            r_val_limit <= 8'hFF;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_KEY_LOW:   r_key_low   <= i_cfg_wdata;
                CFG_KEY_HIGH:  r_key_high  <= i_cfg_wdata;
                CFG_KEY_LEN:   r_key_len   <= i_cfg_wdata[KEY_POS_W-1:0];
                CFG_VAL_LIMIT: r_val_limit <= i_cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg.key_bytes   = {r_key_high, r_key_low};
    assign o_cfg.key_length  = r_key_len;
    assign o_cfg.value_limit = r_val_limit;

endmodule
`default_nettype wire

FILE: rtl/ikv_parse.sv
`default_nettype none
`include "assert_macros.svh"
module ikv_parse
    import ikv_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  t_cfg            i_cfg,
    input  wire logic       i_step,
    input  wire logic [7:0] i_char,
    input  wire logic       i_last,
    output t_result         o_res
);

    t_phase               r_phase,   n_phase;
    logic [KEY_POS_W-1:0] r_key_pos, n_key_pos;
    logic                 r_differs, n_differs;
    logic                 r_matched, n_matched;
    logic [7:0]           r_count,   n_count;

    logic is_sep, is_nul, ends, match_now, byte_ne, emit_ok;

    assign is_sep    = (i_char == SEP_CHAR);
    assign is_nul    = (i_char == NUL_CHAR);
    assign ends      = i_last || is_nul;
    assign match_now = !r_differs && (r_key_pos == i_cfg.key_length);
    assign byte_ne   = (r_key_pos >= i_cfg.key_length) || (r_key_pos >= MAX_KEY_POS)
                     || (i_cfg.key_bytes[{r_key_pos[3:0], 3'b000} +: 8] != i_char);
    assign emit_ok   = r_matched && (r_count < i_cfg.value_limit);

    // next phase
    always_comb begin
        n_phase = r_phase;
        case (r_phase)
            PH_EXPECT: begin
                if (is_sep && !i_last) n_phase = PH_KEY;
                else                   n_phase = ends ? PH_EXPECT : PH_DONE;
            end
            PH_KEY: begin
                if (is_nul)      n_phase = PH_EXPECT;
                else if (is_sep) n_phase = i_last ? PH_EXPECT : PH_VALUE;
                else             n_phase = i_last ? PH_EXPECT : PH_KEY;
            end
            PH_VALUE: begin
                if (is_nul)         n_phase = PH_EXPECT;
                else if (is_sep && i_last) n_phase = PH_EXPECT;
                else if (is_sep)    n_phase = r_matched ? PH_DONE : PH_KEY;
                else                n_phase = i_last ? PH_EXPECT : PH_VALUE;
            end
            PH_DONE: begin
                if (ends) n_phase = PH_EXPECT;
            end
            default: n_phase = PH_EXPECT;
        endcase
    end

    // key tracking, value count and result
    always_comb begin
        n_key_pos = r_key_pos;
        n_differs = r_differs;
        n_matched = r_matched;
        n_count   = r_count;
        o_res     = '0;
        case (r_phase)
            PH_EXPECT: begin
                if (is_sep && !i_last) begin
                    n_key_pos = '0;
                    n_differs = 1'b0;
                    n_matched = 1'b0;
                    n_count   = '0;
                end else begin
                    o_res.valid       = 1'b1;
                    o_res.search_done = 1'b1;
                end
            end
            PH_KEY: begin
                if (is_nul) begin
                    o_res.valid       = 1'b1;
                    o_res.search_done = 1'b1;
                end else if (is_sep) begin
                    n_matched = match_now;
                    n_count   = '0;
                    if (i_last) begin
                        o_res.valid       = 1'b1;
                        o_res.search_done = 1'b1;
                        o_res.key_found   = match_now;
                    end
                end else begin
                    if (byte_ne) n_differs = 1'b1;
                    if (r_key_pos != KEY_POS_SAT) n_key_pos = r_key_pos + 1'b1;
                    if (i_last) begin
                        o_res.valid       = 1'b1;
                        o_res.search_done = 1'b1;
                    end
                end
            end
            PH_VALUE: begin
                if (is_nul) begin
                    o_res.valid        = 1'b1;
                    o_res.search_done  = 1'b1;
                    o_res.key_found    = r_matched;
                    o_res.value_length = r_matched ? r_count : 8'd0;
                end else if (is_sep) begin
                    if (r_matched) begin
                        o_res.valid        = 1'b1;
                        o_res.search_done  = 1'b1;
                        o_res.key_found    = 1'b1;
                        o_res.value_length = r_count;
                    end else if (i_last) begin
                        o_res.valid       = 1'b1;
                        o_res.search_done = 1'b1;
                    end else begin
                        n_key_pos = '0;
                        n_differs = 1'b0;
                        n_matched = 1'b0;
                        n_count   = '0;
                    end
                end else begin
                    if (emit_ok) n_count = r_count + 1'b1;
                    if (i_last) begin
                        o_res.valid            = 1'b1;
                        o_res.value_char       = emit_ok ? i_char : 8'd0;
                        o_res.value_char_valid = emit_ok;
                        o_res.search_done      = 1'b1;
                        o_res.key_found        = r_matched;
                        o_res.value_length     = r_matched ? n_count : 8'd0;
                    end else if (emit_ok) begin
                        o_res.valid            = 1'b1;
                        o_res.value_char       = i_char;
                        o_res.value_char_valid = 1'b1;
                    end
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_EXPECT;
            r_key_pos <= '0;
            r_differs <= 1'b0;
            r_matched <= 1'b0;
            r_count   <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_key_pos <= n_key_pos;
            r_differs <= n_differs;
            r_matched <= n_matched;
            r_count   <= n_count;
        end
    end

    `ASSERT_IMP(a_found_only_when_done, i_clk, i_rst_n, i_step && o_res.key_found, o_res.search_done)
    `ASSERT_IMP(a_byte_needs_match, i_clk, i_rst_n, i_step && o_res.value_char_valid, r_matched && r_phase == PH_VALUE)
    `ASSERT_NXT(a_done_leaves_search, i_clk, i_rst_n, i_step && o_res.search_done && !ends, r_phase == PH_DONE)

endmodule
`default_nettype wire
